// ===== hw/rtl/pngunf_pkg.sv =====
// package for the png scanline unfilter: sizes, filter codes, register indexes,
// the stage word and the paeth predictor
// no dependencies
package pngunf_pkg;

  localparam int unsigned RowMax = 4096;
  localparam int unsigned MaxBpp = 8;
  localparam int unsigned ColW   = $clog2(RowMax);
  localparam int unsigned BselW  = (MaxBpp > 1) ? $clog2(MaxBpp) : 1;

  // widths of the configuration registers
  localparam int unsigned BppW   = 4;
  localparam int unsigned RbW    = 13;
  localparam int unsigned RowsW  = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBytesPerPixel = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRowBytes      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgImageRows     = 2'd2;

  // filter types of a row
  typedef enum logic [2:0] {
    FiltNone  = 3'd0,
    FiltSub   = 3'd1,
    FiltUp    = 3'd2,
    FiltAvg   = 3'd3,
    FiltPaeth = 3'd4
  } filter_e;

  localparam logic [7:0] FiltMaxCode = 8'd4;

  // one data word between input register and result register
  typedef struct packed {
    logic [7:0]      v;
    logic [ColW-1:0] col;
    filter_e         filt;
    logic            err;
    logic            up;
    logic            rend;
    logic            iend;
  } stage_t;

  // paeth predictor on unsigned bytes
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] pa;
    logic signed [10:0] pb;
    logic signed [10:0] pc;
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [7:0]         res;
    pa = $signed({3'b000, b}) - $signed({3'b000, c});
    pb = $signed({3'b000, a}) - $signed({3'b000, c});
    pc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    da = (pa < 0) ? -pa : pa;
    db = (pb < 0) ? -pb : pb;
    dc = (pc < 0) ? -pc : pc;
    if (da <= db && da <= dc) begin
      res = a;
    end else if (db <= dc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/png_scanline_unfilter_top.sv =====
// png scanline unfilter top level: line buffer, stage register, result register
// depends on pngunf_pkg
//
// Usage: the filtered image stream enters one byte per word on the in channel
// (in_valid_i / in_ready_o / stream_byte_i). Each row opens with a filter-type
// byte that gives no result, then row_bytes data bytes follow, each giving one
// word on the out channel (pixel_byte_o, row_end_o, image_end_o, bad_filter_o).
// Throughput is one byte per cycle while the receiver keeps up. A data byte
// that is accepted loads the stage register and the registered line-buffer
// read of the upper neighbour; its reconstruction then goes into the result
// register, from which it shows on out_valid_o.
// A filter-type byte only updates the row state.
// The cfg channel writes bytes_per_pixel, row_bytes and image_rows by index;
// cfg_ready_o is always high and writes are meant for idle periods only.
// Reset puts the block in first-row state with registers at 1; the line buffer
// needs no clearing since the first row never uses it. When the receiver
// stalls, the result register holds, the stage register fills, and in_ready_o
// drops until the result is taken; a waiting result blocks the input only once
// the stage register holds a word as well.
module png_scanline_unfilter_top
  import pngunf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // filtered stream in
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          stream_byte_i,
  // reconstructed bytes out
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          pixel_byte_o,
  output logic                row_end_o,
  output logic                image_end_o,
  output logic                bad_filter_o
);

  // configuration registers
  logic [BppW-1:0]  bpp_q;
  logic [RbW-1:0]   rb_q;
  logic [RowsW-1:0] rows_q;

  // row state
  logic [ColW-1:0]  column_pos_q, column_pos_d;
  logic [RowsW-1:0] row_pos_q, row_pos_d;
  filter_e          row_filter_q, row_filter_d;
  logic             expect_filt_q, expect_filt_d;
  logic             row_err_q, row_err_d;

  // stage register and line buffer read
  stage_t           s1_q, s1_d;
  logic             s1_valid_q;
  logic [7:0]       rd_q;
  logic             byp_q;
  logic [7:0]       byp_data_q;
  logic [7:0]       line_mem [RowMax];

  // neighbour history
  logic [7:0]       left_q [MaxBpp];
  logic [7:0]       upl_q [MaxBpp];

  // result register
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_rend_q;
  logic             out_iend_q;
  logic             out_err_q;

  logic             in_fire;
  logic             data_fire;
  logic             filt_fire;
  logic             s1_move;

  // effective configuration values
  logic [BppW-1:0]  bpp_eff;
  logic [RbW-1:0]   rb_eff;
  logic [RowsW-1:0] rows_eff;
  logic [ColW-1:0]  col;
  logic             rend;
  logic             iend;

  // reconstruction signals
  logic [BselW-1:0] bsel;
  logic             has_left;
  logic [7:0]       a;
  logic [7:0]       b;
  logic [7:0]       c;
  logic [8:0]       avg_sum;
  logic [7:0]       x;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign s1_move     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_move;
  assign in_fire     = in_valid_i && in_ready_o;
  assign filt_fire   = in_fire && expect_filt_q;
  assign data_fire   = in_fire && !expect_filt_q;

  // clamp the configuration to its legal range
  always_comb begin
    bpp_eff = bpp_q;
    if (bpp_q == '0) begin
      bpp_eff = BppW'(1);
    end else if (bpp_q > BppW'(MaxBpp)) begin
      bpp_eff = BppW'(MaxBpp);
    end
    rb_eff = rb_q;
    if (rb_q == '0) begin
      rb_eff = RbW'(1);
    end else if (rb_q > RbW'(RowMax)) begin
      rb_eff = RbW'(RowMax);
    end
    rows_eff = (rows_q == '0) ? RowsW'(1) : rows_q;
  end

  // column, row end and image end for the incoming data byte
  always_comb begin
    logic [RbW-1:0] colx;
    logic [RowsW:0] rnext;
    colx  = RbW'(column_pos_q);
    col   = column_pos_q;
    if (colx >= rb_eff) begin
      col = ColW'(rb_eff - RbW'(1));
    end
    rend  = (RbW'(col) + RbW'(1)) >= rb_eff;
    rnext = {1'b0, row_pos_q} + (RowsW + 1)'(1);
    iend  = rend && (rnext >= {1'b0, rows_eff});
  end

  // next row state and stage word
  always_comb begin
    column_pos_d  = column_pos_q;
    row_pos_d     = row_pos_q;
    row_filter_d  = row_filter_q;
    expect_filt_d = expect_filt_q;
    row_err_d     = row_err_q;
    s1_d.v    = stream_byte_i;
    s1_d.col  = col;
    s1_d.filt = row_filter_q;
    s1_d.err  = row_err_q;
    s1_d.up   = (row_pos_q != '0);
    s1_d.rend = rend;
    s1_d.iend = iend;
    if (filt_fire) begin
      row_err_d     = stream_byte_i > FiltMaxCode;
      row_filter_d  = row_err_d ? FiltNone : filter_e'(stream_byte_i[2:0]);
      expect_filt_d = 1'b0;
    end else if (data_fire) begin
      if (rend) begin
        column_pos_d  = '0;
        expect_filt_d = 1'b1;
        row_pos_d     = iend ? '0 : row_pos_q + RowsW'(1);
      end else begin
        column_pos_d  = col + ColW'(1);
      end
    end
  end

  // neighbours and reconstruction of the staged byte
  always_comb begin
    bsel     = BselW'(bpp_eff - BppW'(1));
    has_left = {{(RbW - ColW){1'b0}}, s1_q.col} >= RbW'(bpp_eff);
    a        = has_left ? left_q[bsel] : 8'd0;
    b        = s1_q.up ? (byp_q ? byp_data_q : rd_q) : 8'd0;
    c        = (has_left && s1_q.up) ? upl_q[bsel] : 8'd0;
    avg_sum  = {1'b0, a} + {1'b0, b};
    case (s1_q.filt)
      FiltSub:   x = s1_q.v + a;
      FiltUp:    x = s1_q.v + b;
      FiltAvg:   x = s1_q.v + avg_sum[8:1];
      FiltPaeth: x = s1_q.v + paeth(a, b, c);
      default:   x = s1_q.v;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q  <= BppW'(1);
      rb_q   <= RbW'(1);
      rows_q <= RowsW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgBytesPerPixel: bpp_q  <= cfg_data_i[BppW-1:0];
        CfgRowBytes:      rb_q   <= cfg_data_i[RbW-1:0];
        CfgImageRows:     rows_q <= cfg_data_i[RowsW-1:0];
        default:          ;
      endcase
    end
  end

  // row state and valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_pos_q  <= '0;
      row_pos_q     <= '0;
      row_filter_q  <= FiltNone;
      expect_filt_q <= 1'b1;
      row_err_q     <= 1'b0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      column_pos_q  <= column_pos_d;
      row_pos_q     <= row_pos_d;
      row_filter_q  <= row_filter_d;
      expect_filt_q <= expect_filt_d;
      row_err_q     <= row_err_d;
      if (data_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // neighbour history, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxBpp; i++) begin
        left_q[i] <= 8'd0;
        upl_q[i]  <= 8'd0;
      end
    end else if (s1_move) begin
      left_q[0] <= x;
      upl_q[0]  <= b;
      for (int i = 1; i < MaxBpp; i++) begin
        left_q[i] <= left_q[i-1];
        upl_q[i]  <= upl_q[i-1];
      end
    end
  end

  // line buffer: write the rebuilt byte, read the upper byte on entry
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      line_mem[s1_q.col] <= x;
    end
    if (data_fire) begin
      rd_q <= line_mem[col];
    end
  end

  // stage payload and forwarding of a same-column write
  always_ff @(posedge clk_i) begin
    if (data_fire) begin
      s1_q       <= s1_d;
      byp_q      <= s1_move && (s1_q.col == col);
      byp_data_q <= x;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_byte_q <= x;
      out_rend_q <= s1_q.rend;
      out_iend_q <= s1_q.iend;
      out_err_q  <= s1_q.err;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = out_byte_q;
  assign row_end_o    = out_rend_q;
  assign image_end_o  = out_iend_q;
  assign bad_filter_o = out_err_q;

`ifndef ASSERT_OFF
  // the last byte of an image always closes a row
  a_iend_rend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!image_end_o || row_end_o))
    else $error("image end without row end");

  // a row end sends the next word to the filter-type decode
  a_rend_filt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (data_fire && rend) |=> expect_filt_q)
    else $error("row end did not rearm filter decode");

  // a stalled result keeps the stage word waiting, never dropped
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |=> s1_valid_q)
    else $error("stage word lost under stall");
`endif

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for png_scanline_unfilter_top: directed and random byte streams,
// a line-level unfilter predictor and a per-word checker
// depends on pngunf_pkg and the png_scanline_unfilter_top rtl
module testbench
  import pngunf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] pix;
    logic       rend;
    logic       iend;
    logic       bad;
  } pixel_word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          stream_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [7:0]          pixel_byte_o;
  logic                row_end_o;
  logic                image_end_o;
  logic                bad_filter_o;

  // predictor state
  logic [7:0]  prior_line [RowMax];
  logic [7:0]  left_hist [MaxBpp];
  logic [7:0]  upleft_hist [MaxBpp];
  int unsigned col_pos;
  int unsigned row_cnt;
  filter_e     cur_filter;
  bit          want_filter;
  bit          cur_bad;
  logic [3:0]  reg_bpp;
  logic [12:0] reg_row_len;
  logic [15:0] reg_rows;

  pixel_word_t expected_pixels [$];
  int          mismatch_count = 0;
  int          words_checked = 0;
  int          bytes_sent = 0;
  bit          sender_no_idle = 1'b0;
  bit          sink_no_idle = 1'b0;
  int          hold_left = 0;

  png_scanline_unfilter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .stream_byte_i(stream_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_byte_o (pixel_byte_o),
    .row_end_o    (row_end_o),
    .image_end_o  (image_end_o),
    .bad_filter_o (bad_filter_o)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // paeth choice among left, upper and upper-left
  function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int da;
    int db;
    int dc;
    da = (int'(b) > int'(c)) ? int'(b) - int'(c) : int'(c) - int'(b);
    db = (int'(a) > int'(c)) ? int'(a) - int'(c) : int'(c) - int'(a);
    dc = int'(a) + int'(b) - 2 * int'(c);
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // rebuild one data byte, or latch the filter type at row start
  function automatic void predict_byte(logic [7:0] v);
    int unsigned bpp;
    int unsigned rb;
    int unsigned rows;
    int unsigned col;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  x;
    logic [8:0]  avg_sum;
    pixel_word_t w;
    if (want_filter) begin
      cur_bad = v > FiltMaxCode;
      cur_filter = cur_bad ? FiltNone : filter_e'(v[2:0]);
      want_filter = 1'b0;
      return;
    end
    bpp = (reg_bpp == 0) ? 1 : reg_bpp;
    if (bpp > MaxBpp) bpp = MaxBpp;
    rb = (reg_row_len == 0) ? 1 : reg_row_len;
    if (rb > RowMax) rb = RowMax;
    rows = (reg_rows == 0) ? 1 : reg_rows;
    col = (col_pos >= rb) ? rb - 1 : col_pos;

    a = (col >= bpp) ? left_hist[bpp-1] : 8'd0;
    b = (row_cnt > 0) ? prior_line[col] : 8'd0;
    c = (col >= bpp && row_cnt > 0) ? upleft_hist[bpp-1] : 8'd0;
    avg_sum = a + b;
    case (cur_filter)
      FiltSub:   x = v + a;
      FiltUp:    x = v + b;
      FiltAvg:   x = v + avg_sum[8:1];
      FiltPaeth: x = v + paeth_pick(a, b, c);
      default:   x = v;
    endcase

    for (int i = MaxBpp - 1; i > 0; i--) begin
      left_hist[i] = left_hist[i-1];
      upleft_hist[i] = upleft_hist[i-1];
    end
    left_hist[0] = x;
    upleft_hist[0] = b;
    prior_line[col] = x;

    w.pix = x;
    w.rend = (col + 1 >= rb);
    w.iend = 1'b0;
    w.bad = cur_bad;
    if (w.rend) begin
      col_pos = 0;
      want_filter = 1'b1;
      if (row_cnt + 1 >= rows) begin
        row_cnt = 0;
        w.iend = 1'b1;
      end else begin
        row_cnt = (row_cnt + 1) & 16'hFFFF;
      end
    end else begin
      col_pos = (col + 1) & 13'h1FFF;
    end
    expected_pixels.push_back(w);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 100)
      $display("mismatch on word %0d: %s got %0h want %0h", words_checked, what, got, want);
    mismatch_count++;
  endtask

  // send one stream byte; valid stays high afterwards so back-to-back words need no toggle
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sender_no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    stream_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_byte(b);
    bytes_sent++;
  endtask

  // stop offering and wait until every expected word has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write all three registers, only while the block is idle
  task automatic set_config(input logic [3:0] bpp, input logic [12:0] rb,
                            input logic [15:0] rows);
    logic [CfgIdxW-1:0]  idxs [3];
    logic [CfgDataW-1:0] vals [3];
    idxs[0] = CfgBytesPerPixel;
    idxs[1] = CfgRowBytes;
    idxs[2] = CfgImageRows;
    vals[0] = {12'd0, bpp};
    vals[1] = {3'd0, rb};
    vals[2] = rows;
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idxs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    reg_bpp = bpp;
    reg_row_len = rb;
    reg_rows = rows;
  endtask

  // reset values of the registers, bad filter code and zero data
  task automatic test_reset_defaults();
    send_byte(8'hFF);
    send_byte(8'hAB);
    send_byte(8'(FiltNone));
    send_byte(8'h00);
    drain_results();
  endtask

  // Paeth in the first row, then Sub, Up, Avg and a bad code in the rows below
  task automatic test_filter_kinds();
    set_config(4'd1, 13'd2, 16'd5);
    send_byte(8'(FiltPaeth)); send_byte(8'hFF); send_byte(8'h80);
    send_byte(8'(FiltSub));   send_byte(8'h01); send_byte(8'hFF);
    send_byte(8'(FiltUp));    send_byte(8'hFF); send_byte(8'h00);
    send_byte(8'(FiltAvg));   send_byte(8'h80); send_byte(8'hFF);
    send_byte(8'd5);          send_byte(8'h12); send_byte(8'h34);
    drain_results();
  endtask

  // shrink row length and image height in the middle of a row
  task automatic test_mid_row_shrink();
    set_config(4'd0, 13'd3, 16'hFFFF);
    send_byte(8'(FiltUp));    send_byte(8'h10); send_byte(8'hFF); send_byte(8'h01);
    send_byte(8'(FiltPaeth)); send_byte(8'h7F);
    drain_results();
    set_config(4'd0, 13'd1, 16'd2);
    send_byte(8'h33);
    drain_results();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_backpressure();
    set_config(4'd3, 13'd20, 16'd2);
    sender_no_idle = 1'b1;
    hold_left = 60;
    for (int r = 0; r < 2; r++) begin
      send_byte(8'($urandom_range(0, 4)));
      for (int k = 0; k < 20; k++) send_byte(8'($urandom));
    end
    sender_no_idle = 1'b0;
    drain_results();
  endtask

  // register values above the clamps, long partial row closed by a shorter row length
  task automatic test_widest_rows();
    set_config(4'hF, 13'h1FFF, 16'd2);
    send_byte(8'($urandom_range(0, 4)));
    for (int k = 0; k < 64; k++) send_byte(8'($urandom));
    drain_results();
    set_config(4'hF, 13'd64, 16'd2);
    send_byte(8'($urandom));
    send_byte(8'($urandom_range(0, 4)));
    for (int k = 0; k < 64; k++) send_byte(8'($urandom));
    drain_results();
  endtask

  // random images under random settings
  task automatic test_random_images(input int n_bytes);
    int          stop_at;
    int unsigned sel;
    logic [3:0]  bpp;
    logic [12:0] rb;
    logic [15:0] rows;
    int unsigned eff_rb;
    int unsigned eff_rows;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      sel = $urandom_range(0, 9);
      bpp = (sel == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
      sel = $urandom_range(0, 19);
      if (sel == 0) rb = 13'd0;
      else if (sel < 4) rb = 13'($urandom_range(17, 64));
      else rb = 13'($urandom_range(1, 16));
      rows = 16'($urandom_range(0, 5));
      set_config(bpp, rb, rows);
      sender_no_idle = ($urandom_range(0, 7) == 0);
      sink_no_idle = ($urandom_range(0, 7) == 0);
      eff_rb = (rb == 0) ? 1 : rb;
      eff_rows = (rows == 0) ? 1 : rows;
      for (int r = 0; r < eff_rows; r++) begin
        if ($urandom_range(0, 6) == 0) send_byte(8'($urandom_range(0, 255)));
        else send_byte(8'($urandom_range(0, 4)));
        for (int k = 0; k < eff_rb; k++) begin
          sel = $urandom_range(0, 9);
          if (sel == 0) send_byte(8'h00);
          else if (sel == 1) send_byte(8'hFF);
          else send_byte(8'($urandom));
        end
      end
      drain_results();
    end
    sender_no_idle = 1'b0;
    sink_no_idle = 1'b0;
  endtask

  // receiver: random gap after each word, plus an optional long hold-off
  initial begin : sink
    int gap;
    gap = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) gap = sink_no_idle ? 0 : $urandom_range(0, 4);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // compare each accepted word with the oldest expectation
  always begin : check_words
    pixel_word_t want;
    @(posedge clk_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("word with nothing expected, pixel_byte", pixel_byte_o, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_byte_o !== want.pix) report_mismatch("pixel_byte", pixel_byte_o, want.pix);
        if (row_end_o !== want.rend) report_mismatch("row_end", row_end_o, want.rend);
        if (image_end_o !== want.iend) report_mismatch("image_end", image_end_o, want.iend);
        if (bad_filter_o !== want.bad) report_mismatch("bad_filter", bad_filter_o, want.bad);
      end
      words_checked++;
    end
  end

  // watchdog
  initial begin
    #6_000_000;
    $display("[png_scanline_unfilter_top] ERROR");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    stream_byte_i <= 8'd0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgBytesPerPixel;
    cfg_data_i <= '0;
    for (int i = 0; i < MaxBpp; i++) begin
      left_hist[i] = 8'd0;
      upleft_hist[i] = 8'd0;
    end
    col_pos = 0;
    row_cnt = 0;
    cur_filter = FiltNone;
    want_filter = 1'b1;
    cur_bad = 1'b0;
    reg_bpp = 4'd1;
    reg_row_len = 13'd1;
    reg_rows = 16'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_filter_kinds();
    test_mid_row_shrink();
    test_output_backpressure();
    test_random_images(1100);
    test_widest_rows();

    drain_results();
    if (mismatch_count == 0) begin
      $display("[png_scanline_unfilter_top] OK");
    end else begin
      $display("[png_scanline_unfilter_top] ERROR");
    end
    $finish;
  end

endmodule
